// ----- sv/lpf_pkg.sv -----
// Shared types and constants of the 3x3 Laplacian filter.
// No dependencies; imported by every other file of the block except lpf_line_store.
`default_nettype none

package lpf_pkg;

   localparam int SAMPLE_W    = 8;
   localparam int GEO_W       = 12;
   localparam int CHN_REG_W   = 3;
   localparam int KSEL_W      = 2;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 12;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_KERNEL_SELECT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT = 8'd3;

   // mask codes
   localparam logic [KSEL_W-1:0] KERNEL_CROSS  = 2'd0;
   localparam logic [KSEL_W-1:0] KERNEL_FULL   = 2'd1;
   localparam logic [KSEL_W-1:0] KERNEL_CORNER = 2'd2;

   localparam logic OP_SAMPLE = 1'b0;

   localparam logic [KSEL_W-1:0]    RESET_KERNEL   = KERNEL_CROSS;
   localparam logic [GEO_W-1:0]     RESET_WIDTH    = 12'd640;
   localparam logic [GEO_W-1:0]     RESET_HEIGHT   = 12'd480;
   localparam logic [CHN_REG_W-1:0] RESET_CHANNELS = 3'd1;

   localparam int CLIP_HIGH = 255;
   localparam int SUM_W     = 13;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } border_type;

   typedef struct packed {
      logic       out;
      logic       eof;
      border_type border;
   } tag_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] up;
      logic [SAMPLE_W-1:0] mid;
      logic [SAMPLE_W-1:0] low;
   } column_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                eof;
   } result_type;

endpackage

`default_nettype wire

// ----- sv/lpf_if.sv -----
// Channel interfaces of the Laplacian filter: sample input, result output, register writes.
// Depends on lpf_pkg.
`default_nettype none

interface lpf_req_if import lpf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                opcode;
   logic [SAMPLE_W-1:0] sample_value;

   modport source (output valid, output opcode, output sample_value, input ready);
   modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

interface lpf_rsp_if import lpf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] filtered_value;
   logic                end_of_frame;

   modport source (output valid, output filtered_value, output end_of_frame, input ready);
   modport sink   (input valid, input filtered_value, input end_of_frame, output ready);
endinterface

interface lpf_csr_if import lpf_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/lpf_line_store.sv -----
// One line store: synchronous RAM, one write and one registered read port.
// A read hitting the entry written in the same cycle returns the new data.
`default_nettype none

module lpf_line_store #(
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = 13,
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [DATA_W-1:0] fwd_data_ff;
   logic              fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/lpf_window.sv -----
// 3x3 window per channel and the mask arithmetic with border zeroing and clipping.
// Depends on lpf_pkg.
`default_nettype none

module lpf_window import lpf_pkg::*; #(
   parameter int CHANNELS = 4,
   parameter int CH_W     = 2
) (
   input  wire logic                clock,
   input  wire logic                shift_en,
   input  wire logic [CH_W-1:0]     shift_ch,
   input  wire column_type          shift_col,
   input  wire logic [CH_W-1:0]     rd_ch,
   input  wire border_type          border,
   input  wire logic [KSEL_W-1:0]   kernel,
   output logic      [SAMPLE_W-1:0] value
);

   column_type left_ff  [CHANNELS];
   column_type ctr_ff   [CHANNELS];
   column_type right_ff [CHANNELS];

   // each channel lane shifts only on its own words
   always_ff @(posedge clock) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if (shift_en && (shift_ch == CH_W'(ch))) begin
            left_ff[ch]  <= ctr_ff[ch];
            ctr_ff[ch]   <= right_ff[ch];
            right_ff[ch] <= shift_col;
         end
      end
   end

   column_type              col_l, col_c, col_r;
   logic signed [SUM_W-1:0] centre, edges, corners, sum;

   always_comb begin
      col_l = left_ff[rd_ch];
      col_c = ctr_ff[rd_ch];
      col_r = right_ff[rd_ch];
      if (border.left) begin
         col_l = '0;
      end
      if (border.right) begin
         col_r = '0;
      end
      if (border.top) begin
         col_l.up = '0;
         col_c.up = '0;
         col_r.up = '0;
      end
      if (border.bottom) begin
         col_l.low = '0;
         col_c.low = '0;
         col_r.low = '0;
      end

      centre  = SUM_W'(col_c.mid);
      edges   = SUM_W'(col_c.up) + SUM_W'(col_c.low) + SUM_W'(col_l.mid) + SUM_W'(col_r.mid);
      corners = SUM_W'(col_l.up) + SUM_W'(col_r.up) + SUM_W'(col_l.low) + SUM_W'(col_r.low);

      case (kernel)
         KERNEL_CROSS:  sum = (centre <<< 2) - edges;
         KERNEL_FULL:   sum = (centre <<< 3) - edges - corners;
         KERNEL_CORNER: sum = (centre <<< 2) - (edges <<< 1) + corners;
         default:       sum = '0;
      endcase

      if (sum < 0) begin
         value = '0;
      end else if (sum > CLIP_HIGH) begin
         value = SAMPLE_W'(CLIP_HIGH);
      end else begin
         value = sum[SAMPLE_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- sv/lpf_out_fifo.sv -----
// Four-entry result queue driving the result channel.
// Depends on lpf_pkg and lpf_rsp_if.
`default_nettype none

module lpf_out_fifo import lpf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire result_type            push_data,
   lpf_rsp_if.source                  rsp,
   output logic      [FIFO_CNT_W-1:0] count
);

   result_type            slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic                  pop;

   assign pop = rsp.valid && rsp.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         count_ff <= count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      end
   end

   assign rsp.valid          = (count_ff != '0);
   assign rsp.filtered_value = slot_ff[rd_ptr_ff].value;
   assign rsp.end_of_frame   = slot_ff[rd_ptr_ff].eof;
   assign count              = count_ff;

endmodule

`default_nettype wire

// ----- sv/laplacian_filter_3x3_unit.sv -----
// Laplacian 3x3 filter, top level. Throughput: one word per cycle on the input channel, except
// while priming or when the result queue has no room. Results pass stage 1, stage 2 and the queue.
// A result is released by the word one row plus one pixel later, or by a flush after frame end.
// One-row frames stall the input channel after their last word while priming steps fill the window.
// Reset is synchronous: registers go to defaults, counters clear, line stores are not cleared.
// Depends on lpf_pkg, lpf_if, lpf_line_store, lpf_window, lpf_out_fifo.
`default_nettype none

module laplacian_filter_3x3_unit import lpf_pkg::*; #(
   parameter int MAX_WIDTH    = 2048,
   parameter int MAX_HEIGHT   = 2048,
   parameter int MAX_CHANNELS = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   lpf_req_if.sink   req_bus,
   lpf_rsp_if.source rsp_bus,
   lpf_csr_if.sink   csr_bus
);

   localparam int IDX_DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int IDX_W     = $clog2(IDX_DEPTH);
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int LAG_W     = $clog2(IDX_DEPTH + MAX_CHANNELS + 1);

   // ------------------------------------------------------------------
   // Configuration registers. Any write to a listed register aborts the
   // frame in progress; the line stores keep their contents.
   // ------------------------------------------------------------------
   logic [KSEL_W-1:0]    kernel_ff, kernel_in;
   logic [GEO_W-1:0]     width_ff, width_in;
   logic [GEO_W-1:0]     height_ff, height_in;
   logic [CHN_REG_W-1:0] chan_ff, chan_in;
   logic                 cfg_wr, cfg_hit;

   assign csr_bus.ready = 1'b1;
   assign cfg_wr        = csr_bus.valid && csr_bus.ready;

   always_comb begin
      kernel_in = kernel_ff;
      width_in  = width_ff;
      height_in = height_ff;
      chan_in   = chan_ff;
      cfg_hit   = 1'b0;
      if (cfg_wr) begin
         case (csr_bus.index)
            REG_KERNEL_SELECT: begin
               kernel_in = csr_bus.data[KSEL_W-1:0];
               cfg_hit   = 1'b1;
            end
            REG_IMAGE_WIDTH: begin
               width_in = csr_bus.data[GEO_W-1:0];
               cfg_hit  = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               height_in = csr_bus.data[GEO_W-1:0];
               cfg_hit   = 1'b1;
            end
            REG_CHANNEL_COUNT: begin
               chan_in = csr_bus.data[CHN_REG_W-1:0];
               cfg_hit = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= RESET_KERNEL;
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         chan_ff   <= RESET_CHANNELS;
      end else begin
         kernel_ff <= kernel_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         chan_ff   <= chan_in;
      end
   end

   // ------------------------------------------------------------------
   // Effective geometry: clamp to 1..MAX, kept as "last index" values.
   // lag = words between a position and the word that completes its window.
   // ------------------------------------------------------------------
   logic [COL_W-1:0] w_last;
   logic [ROW_W-1:0] h_last;
   logic [CH_W-1:0]  c_last;
   logic [LAG_W-1:0] w_cnt, c_cnt, lag;

   always_comb begin
      if (width_ff == '0) begin
         w_last = '0;
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(width_ff - GEO_W'(1));
      end

      if (height_ff == '0) begin
         h_last = '0;
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         h_last = ROW_W'(height_ff - GEO_W'(1));
      end

      if (chan_ff == '0) begin
         c_last = '0;
      end else if (int'(chan_ff) > MAX_CHANNELS) begin
         c_last = CH_W'(MAX_CHANNELS - 1);
      end else begin
         c_last = CH_W'(chan_ff - CHN_REG_W'(1));
      end

      w_cnt = LAG_W'(w_last) + LAG_W'(1);
      c_cnt = LAG_W'(c_last) + LAG_W'(1);
      lag   = LAG_W'((w_cnt + LAG_W'(1)) * c_cnt);
   end

   // ------------------------------------------------------------------
   // Stage 0: position tracking and release decision.
   // The input pointer keeps advancing past frame end (flush and priming
   // steps) so the window keeps shifting; vgap counts its lead over the
   // output pointer, pend the samples not yet answered.
   // ------------------------------------------------------------------
   logic [CH_W-1:0]  in_ch_ff, in_ch_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [IDX_W-1:0] in_idx_ff, in_idx_in;
   logic [CH_W-1:0]  out_ch_ff, out_ch_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [LAG_W-1:0] pend_ff, pend_in;
   logic [LAG_W-1:0] vgap_ff, vgap_in;
   logic             recv_ff, recv_in;

   logic                  req_ready, acc, catchup;
   logic                  is_wr, is_flush_out, out_fire, advance;
   logic                  ch_wrap, col_wrap, out_ch_wrap, out_col_wrap, eof_now, restart;
   logic [FIFO_CNT_W-1:0] fifo_count, credit;
   tag_type               s1_tag_ff, s2_tag_ff;

   // priming: one-row frames end before the window lead is reached
   assign catchup   = recv_ff && (vgap_ff < lag);
   assign credit    = fifo_count + FIFO_CNT_W'(s1_tag_ff.out) + FIFO_CNT_W'(s2_tag_ff.out);
   assign req_ready = !catchup && (credit < FIFO_CNT_W'(FIFO_DEPTH));
   assign req_bus.ready = req_ready;
   assign acc       = req_bus.valid && req_ready;

   // after frame end every word, sample or not, acts as a flush
   assign is_wr        = acc && (req_bus.opcode == OP_SAMPLE) && !recv_ff;
   assign is_flush_out = acc && recv_ff;
   assign out_fire     = (is_wr && (pend_ff >= lag)) || is_flush_out;
   assign advance      = is_wr || is_flush_out || catchup;

   assign ch_wrap      = (in_ch_ff == c_last);
   assign col_wrap     = ch_wrap && (in_col_ff == w_last);
   assign out_ch_wrap  = (out_ch_ff == c_last);
   assign out_col_wrap = out_ch_wrap && (out_col_ff == w_last);
   assign eof_now      = out_col_wrap && (out_row_ff == h_last);
   assign restart      = cfg_hit || (out_fire && eof_now);

   always_comb begin
      in_ch_in   = in_ch_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      in_idx_in  = in_idx_ff;
      out_ch_in  = out_ch_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      recv_in    = recv_ff;

      if (advance) begin
         in_ch_in = ch_wrap ? '0 : in_ch_ff + CH_W'(1);
         if (ch_wrap) begin
            in_col_in = (in_col_ff == w_last) ? '0 : in_col_ff + COL_W'(1);
         end
         in_idx_in = col_wrap ? '0 : in_idx_ff + IDX_W'(1);
      end

      if (is_wr && col_wrap) begin
         if (in_row_ff == h_last) begin
            in_row_in = '0;
            recv_in   = 1'b1;
         end else begin
            in_row_in = in_row_ff + ROW_W'(1);
         end
      end

      if (out_fire) begin
         out_ch_in = out_ch_wrap ? '0 : out_ch_ff + CH_W'(1);
         if (out_ch_wrap) begin
            out_col_in = (out_col_ff == w_last) ? '0 : out_col_ff + COL_W'(1);
         end
         if (out_col_wrap) begin
            out_row_in = out_row_ff + ROW_W'(1);
         end
      end

      pend_in = pend_ff + LAG_W'(is_wr) - LAG_W'(out_fire);
      vgap_in = vgap_ff + LAG_W'(advance) - LAG_W'(out_fire);

      if (restart) begin
         in_ch_in   = '0;
         in_col_in  = '0;
         in_row_in  = '0;
         in_idx_in  = '0;
         out_ch_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         pend_in    = '0;
         vgap_in    = '0;
         recv_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ch_ff   <= '0;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_idx_ff  <= '0;
         out_ch_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pend_ff    <= '0;
         vgap_ff    <= '0;
         recv_ff    <= 1'b0;
      end else begin
         in_ch_ff   <= in_ch_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         in_idx_ff  <= in_idx_in;
         out_ch_ff  <= out_ch_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pend_ff    <= pend_in;
         vgap_ff    <= vgap_in;
         recv_ff    <= recv_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: line store read data arrives; stores rotate (middle row
   // moves to upper) and the new column shifts into the channel's window.
   // ------------------------------------------------------------------
   logic                s1_adv_ff, s1_wr_ff;
   logic [CH_W-1:0]     s1_ch_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [CH_W-1:0]     s2_ch_ff;
   tag_type             tag_in;

   always_comb begin
      tag_in.out           = out_fire;
      tag_in.eof           = out_fire && eof_now;
      tag_in.border.top    = (out_row_ff == '0);
      tag_in.border.bottom = (out_row_ff == h_last);
      tag_in.border.left   = (out_col_ff == '0);
      tag_in.border.right  = (out_col_ff == w_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_adv_ff <= 1'b0;
         s1_wr_ff  <= 1'b0;
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
      end else begin
         s1_adv_ff <= advance;
         s1_wr_ff  <= is_wr;
         s1_tag_ff <= tag_in;
         s2_tag_ff <= s1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ch_ff     <= in_ch_ff;
      s1_idx_ff    <= in_idx_ff;
      s1_sample_ff <= req_bus.sample_value;
      s2_ch_ff     <= s1_ch_ff;
   end

   logic [SAMPLE_W-1:0] upper_rd, middle_rd;
   column_type          new_col;

   lpf_line_store #(
      .DEPTH  (IDX_DEPTH),
      .ADDR_W (IDX_W),
      .DATA_W (SAMPLE_W)
   ) u_upper_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (advance),
      .rd_addr (in_idx_ff),
      .rd_data (upper_rd),
      .wr_en   (s1_wr_ff),
      .wr_addr (s1_idx_ff),
      .wr_data (middle_rd)
   );

   lpf_line_store #(
      .DEPTH  (IDX_DEPTH),
      .ADDR_W (IDX_W),
      .DATA_W (SAMPLE_W)
   ) u_middle_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (advance),
      .rd_addr (in_idx_ff),
      .rd_data (middle_rd),
      .wr_en   (s1_wr_ff),
      .wr_addr (s1_idx_ff),
      .wr_data (s1_sample_ff)
   );

   // bottom row is the word itself; on flush steps it is masked anyway
   assign new_col.up  = upper_rd;
   assign new_col.mid = middle_rd;
   assign new_col.low = s1_sample_ff;

   // ------------------------------------------------------------------
   // Stage 2: mask arithmetic on the updated window, result into the queue.
   // ------------------------------------------------------------------
   logic [SAMPLE_W-1:0] filt_value;
   result_type          push_data;

   lpf_window #(
      .CHANNELS (MAX_CHANNELS),
      .CH_W     (CH_W)
   ) u_window (
      .clock     (clock),
      .shift_en  (s1_adv_ff),
      .shift_ch  (s1_ch_ff),
      .shift_col (new_col),
      .rd_ch     (s2_ch_ff),
      .border    (s2_tag_ff.border),
      .kernel    (kernel_ff),
      .value     (filt_value)
   );

   assign push_data.value = filt_value;
   assign push_data.eof   = s2_tag_ff.eof;

   lpf_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_tag_ff.out),
      .push_data (push_data),
      .rsp       (rsp_bus),
      .count     (fifo_count)
   );

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= lag)
      else $error("pending count beyond window lead");

   a_gap_matches: assert property (@(posedge clock) disable iff (reset)
      !recv_ff |-> (vgap_ff == pend_ff))
      else $error("input pointer lead diverged while streaming");

   a_fifo_room: assert property (@(posedge clock) disable iff (reset)
      s2_tag_ff.out |-> (fifo_count < FIFO_CNT_W'(FIFO_DEPTH)))
      else $error("result pushed into a full queue");

   a_window_fed: assert property (@(posedge clock) disable iff (reset)
      s2_tag_ff.out |-> $past(s1_adv_ff))
      else $error("result computed without a window shift");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for laplacian_filter_3x3_unit: directed and random frames, scored by an in-bench
// line-ring model of the 3x3 Laplacian filter. Depends on lpf_pkg, lpf_if and the filter RTL.

module tb import lpf_pkg::*; ();

   localparam int MAX_W         = 2048;
   localparam int MAX_H         = 2048;
   localparam int MAX_CH        = 4;
   localparam int LINE_DEPTH    = MAX_W * MAX_CH;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 12;  // result pipeline plus one-row priming stall
   localparam int PRINT_CAP     = 40;

   localparam logic OP_FLUSH = 1'b1;
   localparam logic [KSEL_W-1:0] KERNEL_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_LOW  = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_HIGH = 8'hFF;

   logic clock = 1'b0;
   logic reset;

   lpf_req_if req_if ();
   lpf_rsp_if rsp_if ();
   lpf_csr_if csr_if ();

   laplacian_filter_3x3_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Filter model state: four-row line ring, register copies, counters
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0]  row_ring [4][LINE_DEPTH];
   logic [KSEL_W-1:0]    cfg_kernel;
   logic [GEO_W-1:0]     cfg_width;
   logic [GEO_W-1:0]     cfg_height;
   logic [CHN_REG_W-1:0] cfg_chans;
   int  in_col, in_row, in_chan, backlog;
   int  out_col, out_row, out_chan;
   bit  frame_in;   // last word of the frame has been taken

   result_type filtered_due [$];

   int  mismatches;
   int  words_sent;
   int  results_seen;
   int  frames_closed;
   int  cycle_count;
   int  stall_cycles;
   bit  idle_enable;

   function automatic int unsigned clamp_geo(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int mask_tap(input logic [KSEL_W-1:0] k, input int dy, input int dx);
      bit is_center;
      bit on_axis;
      is_center = (dy == 0) && (dx == 0);
      on_axis   = (dy == 0) != (dx == 0);
      case (k)
         KERNEL_CROSS:  return is_center ? 4 : (on_axis ? -1 : 0);
         KERNEL_FULL:   return is_center ? 8 : -1;
         KERNEL_CORNER: return is_center ? 4 : (on_axis ? -2 : 1);
         default:       return 0;  // unused selector: all taps zero
      endcase
   endfunction

   function automatic void rewind_frame();
      in_col   = 0;
      in_row   = 0;
      in_chan  = 0;
      backlog  = 0;
      out_col  = 0;
      out_row  = 0;
      out_chan = 0;
      frame_in = 1'b0;
   endfunction

   // One accepted input word: store the sample, and if it (or a flush) releases a position,
   // queue the clipped convolution for that position.
   function automatic void apply_laplacian_word(input logic op, input logic [SAMPLE_W-1:0] s);
      int w, h, c, lag, sum, y, x, px;
      result_type r;
      w   = clamp_geo(cfg_width, MAX_W);
      h   = clamp_geo(cfg_height, MAX_H);
      c   = clamp_geo(cfg_chans, MAX_CH);
      lag = w * c + c;
      if (op == OP_SAMPLE && !frame_in) begin
         row_ring[in_row % 4][(in_col * c + in_chan) % LINE_DEPTH] = s;
         in_chan++;
         if (in_chan >= c) begin
            in_chan = 0;
            in_col++;
            if (in_col >= w) begin
               in_col = 0;
               in_row++;
               if (in_row >= h) begin
                  in_row   = 0;
                  frame_in = 1'b1;
               end
            end
         end
         backlog++;
         if (backlog <= lag) return;
      end else if (!frame_in || backlog == 0) begin
         // flush before frame end, or a late word with nothing left: no word out
         return;
      end
      sum = 0;
      for (int dy = -1; dy <= 1; dy++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            y = out_row + dy;
            x = out_col + dx;
            if (y >= 0 && y < h && x >= 0 && x < w) begin
               px  = row_ring[y % 4][(x * c + out_chan) % LINE_DEPTH];
               sum += px * mask_tap(cfg_kernel, dy, dx);
            end
         end
      end
      if (sum < 0) sum = 0;
      if (sum > CLIP_HIGH) sum = CLIP_HIGH;
      r.value = sum[SAMPLE_W-1:0];
      r.eof   = 1'b0;
      backlog--;
      out_chan++;
      if (out_chan >= c) begin
         out_chan = 0;
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
            if (out_row >= h) r.eof = 1'b1;
         end
      end
      if (r.eof) rewind_frame();
      filtered_due.push_back(r);
   endfunction

   // ---------------------------------------------------------------------
   // Channel drivers
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("[%0t] %s", $time, what);
   endtask

   // Send one input word; valid stays high, so words go back to back except for idle gaps.
   task automatic send_word(input logic op, input logic [SAMPLE_W-1:0] s);
      int gap;
      gap = (idle_enable && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.opcode       <= op;
      req_if.sample_value <= s;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      words_sent++;
      apply_laplacian_word(op, s);
   endtask

   // Drop valid, let every queued result come out, then cover the pipeline latency.
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (filtered_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      settle();
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (idx)
         REG_KERNEL_SELECT: cfg_kernel = val[KSEL_W-1:0];
         REG_IMAGE_WIDTH:   cfg_width  = val[GEO_W-1:0];
         REG_IMAGE_HEIGHT:  cfg_height = val[GEO_W-1:0];
         REG_CHANNEL_COUNT: cfg_chans  = val[CHN_REG_W-1:0];
         default: ;
      endcase
      // any mapped write aborts the frame in flight
      if (idx <= REG_CHANNEL_COUNT) rewind_frame();
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] k, input logic [CSR_DATA_W-1:0] w,
                               input logic [CSR_DATA_W-1:0] h, input logic [CSR_DATA_W-1:0] c);
      write_reg(REG_KERNEL_SELECT, k);
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      write_reg(REG_CHANNEL_COUNT, c);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return SAMPLE_W'($urandom_range(0, 255));
   endfunction

   // Samples until the frame is complete; noisy mode slips in early flush ticks.
   task automatic stream_frame(input bit noisy);
      while (!frame_in) begin
         if (noisy && $urandom_range(0, 11) == 0) send_word(OP_FLUSH, pick_sample());
         else send_word(OP_SAMPLE, pick_sample());
      end
   endtask

   // Flush ticks until end of frame; noisy mode sends late samples, which act as flushes.
   task automatic drain_frame(input bit noisy);
      while (frame_in) begin
         if (noisy && $urandom_range(0, 7) == 0) send_word(OP_SAMPLE, pick_sample());
         else send_word(OP_FLUSH, pick_sample());
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: random ready bursts, check against the oldest expectation
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_cycles > 0) begin
         stall_cycles--;
         rsp_if.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
         stall_cycles = $urandom_range(1, 15) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_result
      result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (filtered_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word: value %0d eof %b",
                                      rsp_if.filtered_value, rsp_if.end_of_frame));
         end else begin
            want = filtered_due.pop_front();
            results_seen++;
            if (want.eof) frames_closed++;
            if (rsp_if.filtered_value !== want.value)
               report_mismatch($sformatf("filtered_value %0d, expected %0d",
                                         rsp_if.filtered_value, want.value));
            if (rsp_if.end_of_frame !== want.eof)
               report_mismatch($sformatf("end_of_frame %b, expected %b",
                                         rsp_if.end_of_frame, want.eof));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, filtered_due.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset defaults (640x480, one channel): a few words never fill the lag,
   // and a flush before frame end yields nothing.
   task automatic test_reset_defaults();
      send_word(OP_SAMPLE, 8'h00);
      send_word(OP_SAMPLE, 8'hFF);
      send_word(OP_SAMPLE, 8'h5A);
      send_word(OP_FLUSH, 8'hFF);
   endtask

   // Every mask on a 2x2 frame with 0/255 extremes, so both clip rails are hit.
   // Also a late sample acting as flush and a flush after frame end.
   task automatic test_masks();
      logic [SAMPLE_W-1:0] tile [4];
      logic [KSEL_W-1:0]   code [4];
      tile = '{8'hFF, 8'h00, 8'h00, 8'hFF};
      code = '{KERNEL_CROSS, KERNEL_FULL, KERNEL_CORNER, KERNEL_UNUSED};
      for (int k = 0; k < 4; k++) begin
         set_geometry(CSR_DATA_W'(code[k]), 12'd2, 12'd2, 12'd1);
         for (int i = 0; i < 4; i++) send_word(OP_SAMPLE, k[0] ? ~tile[i] : tile[i]);
         send_word(OP_SAMPLE, 8'hA5);
         drain_frame(1'b0);
         send_word(OP_FLUSH, 8'h00);
      end
   endtask

   // Writes to unmapped indexes change nothing and do not abort the frame.
   task automatic test_unmapped_index();
      set_geometry(CSR_DATA_W'(KERNEL_FULL), 12'd3, 12'd2, 12'd1);
      send_word(OP_SAMPLE, 8'h10);
      send_word(OP_SAMPLE, 8'hF0);
      write_reg(REG_UNMAPPED_LOW, 12'hABC);
      write_reg(REG_UNMAPPED_HIGH, 12'hFFF);
      stream_frame(1'b0);
      drain_frame(1'b0);
   endtask

   // Out-of-range geometry: zero sizes act as 1, channel count above 4 as 4,
   // width/height 4095 clamp to 2048 (a short partial frame each, aborted by
   // the next register write).
   task automatic test_geometry_clamps();
      set_geometry(CSR_DATA_W'(KERNEL_FULL), 12'd0, 12'd0, 12'd0);
      send_word(OP_SAMPLE, 8'h21);
      drain_frame(1'b0);
      set_geometry(CSR_DATA_W'(KERNEL_CORNER), 12'd2, 12'd2, 12'd7);
      stream_frame(1'b0);
      drain_frame(1'b0);
      set_geometry(CSR_DATA_W'($urandom_range(0, 3)), 12'hFFF, 12'd1, 12'd1);
      repeat (24) send_word(OP_SAMPLE, pick_sample());
      set_geometry(CSR_DATA_W'($urandom_range(0, 3)), 12'd1, 12'hFFF, 12'd1);
      repeat (24) send_word(OP_SAMPLE, pick_sample());
   endtask

   task automatic pick_random_geometry();
      logic [CSR_DATA_W-1:0] kd, wd, hd, cd;
      kd = CSR_DATA_W'($urandom);      // upper bits are don't-care in the register
      wd = ($urandom_range(0, 11) == 0) ? 12'd0 : CSR_DATA_W'($urandom_range(1, 6));
      hd = ($urandom_range(0, 11) == 0) ? 12'd0 : CSR_DATA_W'($urandom_range(1, 4));
      cd = CSR_DATA_W'($urandom);
      cd[CHN_REG_W-1:0] = ($urandom_range(0, 9) == 0) ? CHN_REG_W'($urandom_range(0, 7))
                                                       : CHN_REG_W'($urandom_range(1, 4));
      set_geometry(kd, wd, hd, cd);
   endtask

   // Mostly whole frames with noise; some frames are cut short and aborted by a register write.
   task automatic test_random_frames(input int budget, input bit with_idle);
      int  stop_at, total, cut;
      bit  need_setup;
      idle_enable = with_idle;
      stop_at     = words_sent + budget;
      need_setup  = 1'b1;
      while (words_sent < stop_at) begin
         if (need_setup || $urandom_range(0, 2) == 0) pick_random_geometry();
         need_setup = 1'b0;
         total = clamp_geo(cfg_width, MAX_W) * clamp_geo(cfg_height, MAX_H)
                 * clamp_geo(cfg_chans, MAX_CH);
         if (total > 1 && $urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, total - 1);
            repeat (cut) send_word(OP_SAMPLE, pick_sample());
            need_setup = 1'b1;
         end else begin
            stream_frame(1'b1);
            drain_frame(1'b1);
            repeat ($urandom_range(0, 2)) send_word(OP_FLUSH, pick_sample());
         end
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.opcode       = OP_SAMPLE;
      req_if.sample_value = '0;
      csr_if.valid        = 1'b0;
      csr_if.index        = REG_KERNEL_SELECT;
      csr_if.data         = '0;
      rsp_if.ready        = 1'b0;
      idle_enable         = 1'b1;
      mismatches          = 0;
      words_sent          = 0;
      results_seen        = 0;
      frames_closed       = 0;
      cycle_count         = 0;
      stall_cycles        = 0;

      // model reset: defaults and zeroed ring
      for (int r = 0; r < 4; r++)
         for (int i = 0; i < LINE_DEPTH; i++) row_ring[r][i] = '0;
      cfg_kernel = RESET_KERNEL;
      cfg_width  = RESET_WIDTH;
      cfg_height = RESET_HEIGHT;
      cfg_chans  = RESET_CHANNELS;
      rewind_frame();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_masks();
      test_unmapped_index();
      test_geometry_clamps();
      test_random_frames(200, 1'b1);
      test_random_frames(50, 1'b0);
      settle();

      $display("Sent %0d input words; checked %0d filtered words and %0d frame ends",
               words_sent, results_seen, frames_closed);
      $display("Covered all masks, clamped geometry, flush noise and aborted frames");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
